[sv/transformed_box_bounds_accumulator_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the transformed box bounds accumulator
// Shared property forms, clocked on i_clk and disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef TRANSFORMED_BOX_BOUNDS_ACCUMULATOR_UNIT_MACROS_SVH
`define TRANSFORMED_BOX_BOUNDS_ACCUMULATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBBA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tbba assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TBBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tbba assertion failed");

`endif

[sv/tbba_pkg.sv]
// ----------------------------------------------------------------------------
// tbba_pkg
// Types and constants shared by the transformed box bounds accumulator.
// ----------------------------------------------------------------------------
package tbba_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int WORD_W        = 32;
    localparam int PROD_W        = 2 * WORD_W;
    // Three full products plus the scaled translation, with headroom.
    localparam int SUM_W         = PROD_W + 2;
    localparam int CFG_W         = 64;
    localparam int NUM_REGS      = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int NUM_AXES      = 3;
    localparam int NUM_CORNERS   = 8;
    localparam int NUM_STAGES    = 5;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic [CFG_W-1:0]         t_cfg;

    localparam t_word WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // Configuration register indexes, in port order.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_R0_C01 = 3'd0,
        REG_R0_C23 = 3'd1,
        REG_R1_C01 = 3'd2,
        REG_R1_C23 = 3'd3,
        REG_R2_C01 = 3'd4,
        REG_R2_C23 = 3'd5
    } t_cfg_reg;

    // Control handed from the pipeline controller to the merge stage.
    typedef struct packed {
        logic en_tree;
        logic en_fold;
        logic restart;
    } t_merge_ctl;

endpackage

[sv/tbba_mul.sv]
// ----------------------------------------------------------------------------
// tbba_mul
// Product stage: every matrix coefficient times both box extents of its column.
// ----------------------------------------------------------------------------
module tbba_mul
    import tbba_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_word i_lo [NUM_AXES],
    input  t_word i_hi [NUM_AXES],
    input  t_word i_coef [NUM_AXES][NUM_AXES],
    output t_prod o_prod_lo [NUM_AXES][NUM_AXES],
    output t_prod o_prod_hi [NUM_AXES][NUM_AXES]
);

    t_prod r_prod_lo [NUM_AXES][NUM_AXES];
    t_prod r_prod_hi [NUM_AXES][NUM_AXES];

    // Indexed [row][column]; the column picks the input axis.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < NUM_AXES; r++) begin
                for (int c = 0; c < NUM_AXES; c++) begin
                    r_prod_lo[r][c] <= t_prod'(i_coef[r][c]) * t_prod'(i_lo[c]);
                    r_prod_hi[r][c] <= t_prod'(i_coef[r][c]) * t_prod'(i_hi[c]);
                end
            end
        end
    end

    assign o_prod_lo = r_prod_lo;
    assign o_prod_hi = r_prod_hi;

endmodule

[sv/tbba_lane.sv]
// ----------------------------------------------------------------------------
// tbba_lane
// One corner lane: sums the row terms, then floors and saturates to a word.
// ----------------------------------------------------------------------------
module tbba_lane
    import tbba_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic  i_clk,
    input  logic  i_en_sum,
    input  logic  i_en_sat,
    input  t_prod i_prod [NUM_AXES][NUM_AXES],
    input  t_word i_trans [NUM_AXES],
    output t_word o_world [NUM_AXES]
);

    t_sum  r_sum   [NUM_AXES];
    t_word r_world [NUM_AXES];

    // Arithmetic shift floors toward minus infinity; anything that does not
    // fit in a word clamps to the end of the range on its sign.
    function automatic t_word floor_sat(input t_sum s);
        t_sum q;
        q = s >>> FRAC_BITS;
        if (q[SUM_W-1:WORD_W-1] == {(SUM_W-WORD_W+1){q[SUM_W-1]}}) begin
            return q[WORD_W-1:0];
        end
        return q[SUM_W-1] ? WORD_MIN : WORD_MAX;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            for (int r = 0; r < NUM_AXES; r++) begin
                r_sum[r] <= t_sum'(i_prod[r][0]) + t_sum'(i_prod[r][1])
                          + t_sum'(i_prod[r][2]) + (t_sum'(i_trans[r]) <<< FRAC_BITS);
            end
        end
        if (i_en_sat) begin
            for (int r = 0; r < NUM_AXES; r++) begin
                r_world[r] <= floor_sat(r_sum[r]);
            end
        end
    end

    assign o_world = r_world;

endmodule

[sv/tbba_merge.sv]
// ----------------------------------------------------------------------------
// tbba_merge
// Merges the corner lanes into per-box extremes and folds them into the bounds.
// ----------------------------------------------------------------------------
module tbba_merge
    import tbba_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_merge_ctl i_ctl,
    input  t_word      i_world [NUM_CORNERS][NUM_AXES],
    output t_word      o_min [NUM_AXES],
    output t_word      o_max [NUM_AXES]
);

    localparam int HALF = NUM_CORNERS / 2;

    t_word r_pmin [2][NUM_AXES];
    t_word r_pmax [2][NUM_AXES];
    logic  r_restart;
    t_word r_acc_min [NUM_AXES];
    t_word r_acc_max [NUM_AXES];
    t_word n_acc_min [NUM_AXES];
    t_word n_acc_max [NUM_AXES];

    function automatic t_word smin(input t_word a, input t_word b);
        return (b < a) ? b : a;
    endfunction

    function automatic t_word smax(input t_word a, input t_word b);
        return (b > a) ? b : a;
    endfunction

    // First level: each half of the corners reduced in a two-deep tree.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_tree) begin
            for (int h = 0; h < 2; h++) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    r_pmin[h][a] <= smin(smin(i_world[h*HALF][a], i_world[h*HALF+1][a]),
                                         smin(i_world[h*HALF+2][a], i_world[h*HALF+3][a]));
                    r_pmax[h][a] <= smax(smax(i_world[h*HALF][a], i_world[h*HALF+1][a]),
                                         smax(i_world[h*HALF+2][a], i_world[h*HALF+3][a]));
                end
            end
            r_restart <= i_ctl.restart;
        end
    end

    // A restart drops the old bounds so this box alone sets them.
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            n_acc_min[a] = smin(r_pmin[0][a], r_pmin[1][a]);
            n_acc_max[a] = smax(r_pmax[0][a], r_pmax[1][a]);
            if (!r_restart) begin
                n_acc_min[a] = smin(r_acc_min[a], n_acc_min[a]);
                n_acc_max[a] = smax(r_acc_max[a], n_acc_max[a]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_acc_min[a] <= WORD_MAX;
                r_acc_max[a] <= WORD_MIN;
            end
        end else if (i_ctl.en_fold) begin
            r_acc_min <= n_acc_min;
            r_acc_max <= n_acc_max;
        end
    end

    assign o_min = r_acc_min;
    assign o_max = r_acc_max;

endmodule

[sv/transformed_box_bounds_accumulator_unit.sv]
// ----------------------------------------------------------------------------
// transformed_box_bounds_accumulator_unit
// Transforms the eight corners of each box by an affine 3x4 matrix and keeps
// a running world-space minimum and maximum, one result per box.
// ----------------------------------------------------------------------------
//
//   Channel  | Direction | Handshake              | Payload
//   ---------+-----------+------------------------+-------------------------------
//   box in   | input     | i_valid / o_stall      | i_restart, i_box_min_*, i_box_max_*
//   bounds   | output    | o_valid / i_stall      | o_bound_min_*, o_bound_max_*
//   config   | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A box is taken every cycle while o_stall is low. Its bounds pass through the
// product, lane sum, floor and saturate, merge tree and fold registers, and leave
// when nothing stalls. The rate is set by the fold of the per-box extremes into
// the accumulator registers at the last stage.
// Reset (synchronous, active low) loads the identity matrix and empty bounds.
// Each stage holds its item while the one ahead is full, so a stall on the
// output fills the empty stages before o_stall rises.
// Configuration writes are always taken and are written straight into the registers.
//
module transformed_box_bounds_accumulator_unit
    import tbba_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Box input channel.
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_restart,
    input  logic signed [31:0]   i_box_min_x,
    input  logic signed [31:0]   i_box_min_y,
    input  logic signed [31:0]   i_box_min_z,
    input  logic signed [31:0]   i_box_max_x,
    input  logic signed [31:0]   i_box_max_y,
    input  logic signed [31:0]   i_box_max_z,
    // Bounds output channel.
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [31:0]   o_bound_min_x,
    output logic signed [31:0]   o_bound_min_y,
    output logic signed [31:0]   o_bound_min_z,
    output logic signed [31:0]   o_bound_max_x,
    output logic signed [31:0]   o_bound_max_y,
    output logic signed [31:0]   o_bound_max_z,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // 1.0 in the fixed-point format, used for the identity at reset.
    localparam t_cfg ONE_LO = t_cfg'(1) << FRAC_BITS;
    localparam t_cfg ONE_HI = ONE_LO << WORD_W;

    // Stage map: 0 products, 1 lane sums, 2 lane floor and saturate,
    // 3 merge tree, 4 fold into the bounds (this is the output register).
    localparam int ST_FOLD = NUM_STAGES - 1;

    t_cfg                  r_cfg [NUM_REGS];
    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] w_ready;
    logic [2:0]            r_restart;

    t_word      w_coef   [NUM_AXES][NUM_AXES];
    t_word      w_trans  [NUM_AXES];
    t_word      w_lo     [NUM_AXES];
    t_word      w_hi     [NUM_AXES];
    t_prod      w_prod_lo [NUM_AXES][NUM_AXES];
    t_prod      w_prod_hi [NUM_AXES][NUM_AXES];
    t_word      w_world  [NUM_CORNERS][NUM_AXES];
    t_word      w_min    [NUM_AXES];
    t_word      w_max    [NUM_AXES];
    t_merge_ctl w_mctl;

    // ------------------------------------------------------------------
    // Configuration registers. Writes to an index past the last register
    // are dropped.
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_R0_C01] <= ONE_LO;
            r_cfg[REG_R0_C23] <= '0;
            r_cfg[REG_R1_C01] <= ONE_HI;
            r_cfg[REG_R1_C23] <= '0;
            r_cfg[REG_R2_C01] <= '0;
            r_cfg[REG_R2_C23] <= ONE_LO;
        end else if (i_cfg_valid && o_cfg_ready && i_cfg_index <= REG_R2_C23) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // Each row is two registers: columns 0 and 1, then column 2 and the
    // translation, low half first.
    always_comb begin
        for (int r = 0; r < NUM_AXES; r++) begin
            w_coef[r][0] = r_cfg[2*r][WORD_W-1:0];
            w_coef[r][1] = r_cfg[2*r][CFG_W-1:WORD_W];
            w_coef[r][2] = r_cfg[2*r+1][WORD_W-1:0];
            w_trans[r]   = r_cfg[2*r+1][CFG_W-1:WORD_W];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. A stage can load when it is empty or when the
    // stage ahead of it can load too; bubbles close up under a stall.
    // ------------------------------------------------------------------
    always_comb begin
        w_ready[ST_FOLD] = !r_valid[ST_FOLD] || !i_stall;
        for (int k = ST_FOLD - 1; k >= 0; k--) begin
            w_ready[k] = !r_valid[k] || w_ready[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_ready[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_ready[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // The restart flag rides along with its box up to the merge stage.
    always_ff @(posedge i_clk) begin
        if (w_ready[0]) begin
            r_restart[0] <= i_restart;
        end
        if (w_ready[1]) begin
            r_restart[1] <= r_restart[0];
        end
        if (w_ready[2]) begin
            r_restart[2] <= r_restart[1];
        end
    end

    assign o_stall = !w_ready[0];
    assign o_valid = r_valid[ST_FOLD];

    // ------------------------------------------------------------------
    // Datapath: shared products, eight corner lanes, merge and fold.
    // ------------------------------------------------------------------
    assign w_lo = '{i_box_min_x, i_box_min_y, i_box_min_z};
    assign w_hi = '{i_box_max_x, i_box_max_y, i_box_max_z};

    tbba_mul u_mul (
        .i_clk     (i_clk),
        .i_en      (w_ready[0]),
        .i_lo      (w_lo),
        .i_hi      (w_hi),
        .i_coef    (w_coef),
        .o_prod_lo (w_prod_lo),
        .o_prod_hi (w_prod_hi)
    );

    // Bit k of the corner number picks the maximum extent on axis k, so
    // each lane just selects between the two products of every column.
    for (genvar g = 0; g < NUM_CORNERS; g++) begin : g_lane
        t_prod w_sel [NUM_AXES][NUM_AXES];

        always_comb begin
            for (int r = 0; r < NUM_AXES; r++) begin
                for (int c = 0; c < NUM_AXES; c++) begin
                    w_sel[r][c] = (((g >> c) & 1) != 0) ? w_prod_hi[r][c] : w_prod_lo[r][c];
                end
            end
        end

        tbba_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_en_sum (w_ready[1]),
            .i_en_sat (w_ready[2]),
            .i_prod   (w_sel),
            .i_trans  (w_trans),
            .o_world  (w_world[g])
        );
    end

    // The fold only happens for a real box moving into the output register.
    assign w_mctl.en_tree = w_ready[3];
    assign w_mctl.en_fold = r_valid[3] && w_ready[ST_FOLD];
    assign w_mctl.restart = r_restart[2];

    tbba_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mctl),
        .i_world (w_world),
        .o_min   (w_min),
        .o_max   (w_max)
    );

    // The accumulator itself is the output register; it only moves when the
    // previous result has been taken.
    assign o_bound_min_x = w_min[0];
    assign o_bound_min_y = w_min[1];
    assign o_bound_min_z = w_min[2];
    assign o_bound_max_x = w_max[0];
    assign o_bound_max_y = w_max[1];
    assign o_bound_max_z = w_max[2];

endmodule

[sv/tbba_chk.sv]
// ----------------------------------------------------------------------------
// tbba_chk
// Port-level checks for the transformed box bounds accumulator, bound to it.
// ----------------------------------------------------------------------------
`include "transformed_box_bounds_accumulator_unit_macros.svh"

module tbba_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic signed [31:0]   o_bound_min_x,
    input logic signed [31:0]   o_bound_min_y,
    input logic signed [31:0]   o_bound_min_z,
    input logic signed [31:0]   o_bound_max_x,
    input logic signed [31:0]   o_bound_max_y,
    input logic signed [31:0]   o_bound_max_z
);

    // A result held under a stall keeps its bounds; only min x and max z are checked.
    `TBBA_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_bound_min_x) && $stable(o_bound_max_z))

    // Bounds come from the same corners, so a delivered minimum never exceeds the maximum.
    `TBBA_ASSERT_SAME(a_min_le_max, o_valid, o_bound_min_x <= o_bound_max_x && o_bound_min_y <= o_bound_max_y && o_bound_min_z <= o_bound_max_z)

    // With the output register empty every stage can advance, so input is never held off.
    `TBBA_ASSERT_SAME(a_no_stall_when_empty, !o_valid, !o_stall)

    // No result is shown in the first cycle out of reset.
    `TBBA_ASSERT_SAME(a_quiet_after_reset, !$past(i_rst_n), !o_valid)

endmodule

bind transformed_box_bounds_accumulator_unit tbba_chk u_tbba_chk (.*);
